>>> src/jtss_pkg.sv
// ----------------------------------------------------------------------------
// jtss_pkg: shared types, codes and byte classes
// Scan states, role and status codes, and the per-byte result record of the
// JSON top-level string pair scanner.
// ----------------------------------------------------------------------------
package jtss_pkg;

	localparam int BYTE_W       = 8;
	localparam int ROLE_W       = 2;
	localparam int STATUS_W     = 2;
	localparam int PAIRS_W      = 16;
	localparam int MAX_NEST_DEF = 255;
	localparam int COUNT_BITS_DEF = 16;

	typedef enum logic [3:0] {
		ST_START     = 4'd0,
		ST_OBJ       = 4'd1,
		ST_COMMA     = 4'd2,
		ST_FNAME     = 4'd3,
		ST_FNAME_ESC = 4'd4,
		ST_COLON     = 4'd5,
		ST_VALUE     = 4'd6,
		ST_SCALAR    = 4'd7,
		ST_SVAL      = 4'd8,
		ST_SVAL_ESC  = 4'd9,
		ST_NEST      = 4'd10,
		ST_NSTR      = 4'd11,
		ST_NSTR_ESC  = 4'd12,
		ST_DONE      = 4'd13,
		ST_ERR       = 4'd14
	} jtss_state_t;

	localparam logic [ROLE_W-1:0] ROLE_NONE  = 2'd0;
	localparam logic [ROLE_W-1:0] ROLE_FIELD = 2'd1;
	localparam logic [ROLE_W-1:0] ROLE_VALUE = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_BUSY = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd2;

	localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7B;
	localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7D;
	localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
	localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

	typedef struct packed {
		logic [BYTE_W-1:0]   echo_byte;
		logic [ROLE_W-1:0]   byte_role;
		logic                field_closed;
		logic                pair_closed;
		logic                value_skipped;
		logic [STATUS_W-1:0] parse_status;
		logic [PAIRS_W-1:0]  pairs_found;
		logic                doc_end;
	} jtss_res_t;

	function automatic logic is_ws(input logic [BYTE_W-1:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	// next state for a byte seen between pairs
	function automatic jtss_state_t between_pairs(input logic [BYTE_W-1:0] c);
		jtss_state_t s;
		if (is_ws(c)) begin
			s = ST_OBJ;
		end else if (c == CH_RBRACE) begin
			s = ST_DONE;
		end else if (c == CH_COMMA) begin
			s = ST_COMMA;
		end else if (c == CH_QUOTE) begin
			s = ST_FNAME;
		end else begin
			s = ST_ERR;
		end
		return s;
	endfunction

endpackage

>>> src/jtss_if.sv
// ----------------------------------------------------------------------------
// jtss_in_if / jtss_out_if: valid-ready channels
// Document byte channel into the scanner and result channel out of it.
// ----------------------------------------------------------------------------
interface jtss_in_if;
	import jtss_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] doc_byte;
	logic              doc_last;

	modport source(output valid, doc_byte, doc_last, input ready);
	modport sink(input valid, doc_byte, doc_last, output ready);
endinterface

interface jtss_out_if;
	import jtss_pkg::*;

	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   echo_byte;
	logic [ROLE_W-1:0]   byte_role;
	logic                field_closed;
	logic                pair_closed;
	logic                value_skipped;
	logic [STATUS_W-1:0] parse_status;
	logic [PAIRS_W-1:0]  pairs_found;
	logic                doc_end;

	modport source(
		output valid, echo_byte, byte_role, field_closed, pair_closed, value_skipped,
		       parse_status, pairs_found, doc_end,
		input  ready
	);
	modport sink(
		input  valid, echo_byte, byte_role, field_closed, pair_closed, value_skipped,
		       parse_status, pairs_found, doc_end,
		output ready
	);
endinterface

>>> src/json_top_level_string_pair_scanner.sv
// ----------------------------------------------------------------------------
// json_top_level_string_pair_scanner
// Tags each byte of a JSON document as field name, string value or neither,
// and flags field ends, completed string pairs and skipped values.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                        transfer when
//  doc_in    in   doc_byte, doc_last                             valid & ready
//  res_out   out  echo_byte, byte_role, flags, status, pairs,    valid & ready
//                 doc_end
//
//  One byte per clock while res_out is ready; each result passes through the
//  input register, then the scan logic into the result register, from which
//  it can transfer out.
//  The scan state, nesting depth and pair tally update as a byte moves into the
//  result register; the last byte of a document returns them to reset.
//  A stalled result holds its register; one further byte is taken into the
//  input register while the result waits.
//  Reset clears the state and both valid flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module json_top_level_string_pair_scanner #(
	parameter int MAX_NEST   = jtss_pkg::MAX_NEST_DEF,
	parameter int COUNT_BITS = jtss_pkg::COUNT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	jtss_in_if.sink           doc_in,
	jtss_out_if.source        res_out
);
	import jtss_pkg::*;

	localparam int NEST_BITS = $clog2(MAX_NEST + 1);

	logic                  valid_s1;
	logic [BYTE_W-1:0]     byte_s1;
	logic                  last_s1;
	logic                  valid_s2;
	jtss_res_t             res_s2;

	jtss_state_t           state_q;
	logic [NEST_BITS-1:0]  depth_q;
	logic [COUNT_BITS-1:0] tally_q;

	jtss_state_t           state_nxt;
	logic [NEST_BITS-1:0]  depth_nxt;
	logic [COUNT_BITS-1:0] tally_nxt;
	jtss_res_t             res_nxt;

	logic                  adv_s2;
	logic                  adv_s1;
	logic                  take_in;

	// advance the result register when it is empty or being taken
	assign adv_s2  = !valid_s2 || res_out.ready;
	assign adv_s1  = valid_s1 && adv_s2;
	assign doc_in.ready = !valid_s1 || adv_s2;
	assign take_in = doc_in.valid && doc_in.ready;

	jtss_step #(
		.MAX_NEST   (MAX_NEST),
		.COUNT_BITS (COUNT_BITS),
		.NEST_BITS  (NEST_BITS)
	) u_step (
		.state     (state_q),
		.depth     (depth_q),
		.tally     (tally_q),
		.c         (byte_s1),
		.last      (last_s1),
		.state_nxt (state_nxt),
		.depth_nxt (depth_nxt),
		.tally_nxt (tally_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (doc_in.ready) begin
			valid_s1 <= doc_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= doc_in.doc_byte;
			last_s1 <= doc_in.doc_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			state_q  <= ST_START;
			depth_q  <= '0;
			tally_q  <= '0;
		end else begin
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s1) begin
				state_q <= state_nxt;
				depth_q <= depth_nxt;
				tally_q <= tally_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) res_s2 <= res_nxt;
	end

	assign res_out.valid         = valid_s2;
	assign res_out.echo_byte     = res_s2.echo_byte;
	assign res_out.byte_role     = res_s2.byte_role;
	assign res_out.field_closed  = res_s2.field_closed;
	assign res_out.pair_closed   = res_s2.pair_closed;
	assign res_out.value_skipped = res_s2.value_skipped;
	assign res_out.parse_status  = res_s2.parse_status;
	assign res_out.pairs_found   = res_s2.pairs_found;
	assign res_out.doc_end       = res_s2.doc_end;

	a_doc_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (state_q == ST_START && depth_q == '0 && tally_q == '0))
		else $error("state not cleared after last byte");

	a_tally_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !last_s1) |=> (tally_q >= $past(tally_q)))
		else $error("pair tally went down inside a document");

	a_quote_role: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (res_s2.pair_closed || res_s2.field_closed)) |->
		(res_s2.byte_role == ROLE_NONE && !(res_s2.pair_closed && res_s2.field_closed)))
		else $error("closing quote tagged with a role");

	a_malformed_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.parse_status == STATUS_BAD && !res_s2.doc_end) |->
		(res_s2.byte_role == ROLE_NONE && !res_s2.field_closed && !res_s2.pair_closed
		 && !res_s2.value_skipped))
		else $error("malformed document still reporting");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= NEST_BITS'(MAX_NEST))
		else $error("nesting depth beyond limit");

endmodule

>>> src/jtss_step.sv
// ----------------------------------------------------------------------------
// jtss_step: per-byte scan logic
// Given the scan state and one byte, work out the next state, nesting depth,
// pair tally and the result record for that byte.
// ----------------------------------------------------------------------------
module jtss_step #(
	parameter int MAX_NEST   = jtss_pkg::MAX_NEST_DEF,
	parameter int COUNT_BITS = jtss_pkg::COUNT_BITS_DEF,
	parameter int NEST_BITS  = $clog2(MAX_NEST + 1)
) (
	input  jtss_pkg::jtss_state_t         state,
	input  logic [NEST_BITS-1:0]          depth,
	input  logic [COUNT_BITS-1:0]         tally,
	input  logic [jtss_pkg::BYTE_W-1:0]   c,
	input  logic                          last,
	output jtss_pkg::jtss_state_t         state_nxt,
	output logic [NEST_BITS-1:0]          depth_nxt,
	output logic [COUNT_BITS-1:0]         tally_nxt,
	output jtss_pkg::jtss_res_t           res
);
	import jtss_pkg::*;

	localparam logic [NEST_BITS-1:0] NEST_TOP = NEST_BITS'(MAX_NEST);

	jtss_state_t               s;
	logic [NEST_BITS-1:0]      d;
	logic [NEST_BITS-1:0]      d_dec;
	logic [COUNT_BITS-1:0]     t;
	logic [ROLE_W-1:0]         role;
	logic                      fc;
	logic                      pc;
	logic                      vs;
	logic [COUNT_BITS+15:0]    t_ext;

	always_comb begin
		s     = state;
		d     = depth;
		t     = tally;
		role  = ROLE_NONE;
		fc    = 1'b0;
		pc    = 1'b0;
		vs    = 1'b0;
		d_dec = (depth != '0) ? depth - NEST_BITS'(1) : '0;
		case (state)
			ST_START: begin
				if (c == CH_LBRACE) begin
					s = ST_OBJ;
				end else if (!is_ws(c)) begin
					s = ST_ERR;
				end
			end
			ST_OBJ: begin
				s = between_pairs(c);
			end
			ST_COMMA: begin
				if (c == CH_QUOTE) begin
					s = ST_FNAME;
				end else if (!is_ws(c)) begin
					s = ST_ERR;
				end
			end
			ST_FNAME: begin
				if (c == CH_QUOTE) begin
					fc = 1'b1;
					s  = ST_COLON;
				end else begin
					role = ROLE_FIELD;
					if (c == CH_BSLASH) s = ST_FNAME_ESC;
				end
			end
			ST_FNAME_ESC: begin
				role = ROLE_FIELD;
				s    = ST_FNAME;
			end
			ST_COLON: begin
				if (c == CH_COLON) begin
					s = ST_VALUE;
				end else if (!is_ws(c)) begin
					s = ST_ERR;
				end
			end
			ST_VALUE: begin
				if (is_ws(c)) begin
					s = ST_VALUE;
				end else if (c == CH_QUOTE) begin
					s = ST_SVAL;
				end else if (c inside {CH_LBRACE, CH_LBRACK}) begin
					d = NEST_BITS'(1);
					s = ST_NEST;
				end else if (c inside {CH_COMMA, CH_RBRACE, CH_RBRACK}) begin
					// empty scalar: the delimiter is read again between pairs
					vs = 1'b1;
					s  = between_pairs(c);
				end else begin
					s = ST_SCALAR;
				end
			end
			ST_SCALAR: begin
				if ((c inside {CH_COMMA, CH_RBRACE, CH_RBRACK}) || is_ws(c)) begin
					vs = 1'b1;
					s  = between_pairs(c);
				end
			end
			ST_SVAL: begin
				if (c == CH_QUOTE) begin
					pc = 1'b1;
					if (tally != '1) t = tally + COUNT_BITS'(1);
					s  = ST_OBJ;
				end else begin
					role = ROLE_VALUE;
					if (c == CH_BSLASH) s = ST_SVAL_ESC;
				end
			end
			ST_SVAL_ESC: begin
				role = ROLE_VALUE;
				s    = ST_SVAL;
			end
			ST_NEST: begin
				if (c inside {CH_LBRACE, CH_LBRACK}) begin
					if (depth >= NEST_TOP) begin
						s = ST_ERR;
					end else begin
						d = depth + NEST_BITS'(1);
					end
				end else if (c inside {CH_RBRACE, CH_RBRACK}) begin
					d = d_dec;
					if (d_dec == '0) begin
						vs = 1'b1;
						s  = ST_OBJ;
					end
				end else if (c == CH_QUOTE) begin
					s = ST_NSTR;
				end
			end
			ST_NSTR: begin
				if (c == CH_BSLASH) begin
					s = ST_NSTR_ESC;
				end else if (c == CH_QUOTE) begin
					s = ST_NEST;
				end
			end
			ST_NSTR_ESC: begin
				s = ST_NSTR;
			end
			ST_DONE: begin
				s = ST_DONE;
			end
			default: begin
				s = ST_ERR;
			end
		endcase

		// a malformed document reports nothing further
		if (s == ST_ERR) begin
			role = ROLE_NONE;
			fc   = 1'b0;
			pc   = 1'b0;
			vs   = 1'b0;
		end
	end

	assign t_ext = {16'd0, t};

	always_comb begin
		res.echo_byte     = c;
		res.byte_role     = role;
		res.field_closed  = fc;
		res.pair_closed   = pc;
		res.value_skipped = vs;
		if (s == ST_DONE) begin
			res.parse_status = STATUS_OK;
		end else if (s == ST_ERR || last) begin
			res.parse_status = STATUS_BAD;
		end else begin
			res.parse_status = STATUS_BUSY;
		end
		res.pairs_found = (t_ext > (COUNT_BITS+16)'(16'hFFFF)) ? '1 : t_ext[15:0];
		res.doc_end     = last;
	end

	// the last byte returns everything to its reset value
	always_comb begin
		if (last) begin
			state_nxt = ST_START;
			depth_nxt = '0;
			tally_nxt = '0;
		end else begin
			state_nxt = s;
			depth_nxt = d;
			tally_nxt = t;
		end
	end

endmodule

>>> verif/json_top_level_string_pair_scanner_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_top_level_string_pair_scanner_test
// Feeds JSON documents byte by byte into the scanner and checks every result
// against a local scan predictor. A short table of directed bytes comes first,
// then random documents: mostly well-formed, some mangled, some pure noise.
// Then come a long document of back to back pairs, and two nested values,
// one at the deepest allowed nesting and one a level past it.
// ----------------------------------------------------------------------------
module json_top_level_string_pair_scanner_test;
	import jtss_pkg::*;

	localparam int        CYCLE_LIMIT  = 2_000_000;
	localparam int        RANDOM_ITEMS = 900;
	localparam int        LONG_PAIRS   = 20;
	localparam int        NEST_LIMIT   = MAX_NEST_DEF;
	localparam longint    TALLY_TOP    = (64'd1 << COUNT_BITS_DEF) - 1;
	localparam int        DIR_ROWS     = 25;

	typedef struct packed {
		logic [BYTE_W-1:0]   b;
		logic                l;
		logic                pin;
		logic [ROLE_W-1:0]   role;
		logic [STATUS_W-1:0] st;
		logic [PAIRS_W-1:0]  pairs;
	} stim_row_t;

	logic clk;
	logic arst_n;

	jtss_in_if  doc_in();
	jtss_out_if res_out();

	json_top_level_string_pair_scanner u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.doc_in  (doc_in),
		.res_out (res_out)
	);

	// predictor state
	jtss_state_t     scan_st    = ST_START;
	int              nest_lvl   = 0;
	longint unsigned pair_tally = 0;

	jtss_res_t       pending_results[$];
	logic            pin_on;
	jtss_res_t       pin_res;
	bit              idle_en    = 1'b1;
	int              fail_count = 0;
	int              cycles     = 0;
	logic [BYTE_W-1:0] doc_buf[$];
	stim_row_t       dir_table[DIR_ROWS];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(negedge clk) begin
		res_out.ready <= idle_en ? ($urandom_range(0, 99) >= 36) : 1'b1;
	end

	function automatic bit is_blank(input logic [BYTE_W-1:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
	endfunction

	function automatic jtss_state_t after_pair(input logic [BYTE_W-1:0] c);
		if (is_blank(c))
			return ST_OBJ;
		if (c == CH_RBRACE)
			return ST_DONE;
		if (c == CH_COMMA)
			return ST_COMMA;
		if (c == CH_QUOTE)
			return ST_FNAME;
		return ST_ERR;
	endfunction

	function automatic bit ends_scalar(input logic [BYTE_W-1:0] c);
		return is_blank(c) || c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACK;
	endfunction

	// advance the scan by one byte and return the result it gives
	function automatic jtss_res_t scan_step(input logic [BYTE_W-1:0] c, input logic l);
		jtss_res_t   r;
		jtss_state_t nxt;
		r   = '0;
		nxt = scan_st;
		case (scan_st)
			ST_START: begin
				if (c == CH_LBRACE)
					nxt = ST_OBJ;
				else if (!is_blank(c))
					nxt = ST_ERR;
			end
			ST_OBJ: nxt = after_pair(c);
			ST_COMMA: begin
				if (c == CH_QUOTE)
					nxt = ST_FNAME;
				else if (!is_blank(c))
					nxt = ST_ERR;
			end
			ST_FNAME: begin
				if (c == CH_QUOTE) begin
					r.field_closed = 1'b1;
					nxt = ST_COLON;
				end else begin
					r.byte_role = ROLE_FIELD;
					if (c == CH_BSLASH)
						nxt = ST_FNAME_ESC;
				end
			end
			ST_FNAME_ESC: begin
				r.byte_role = ROLE_FIELD;
				nxt = ST_FNAME;
			end
			ST_COLON: begin
				if (c == CH_COLON)
					nxt = ST_VALUE;
				else if (!is_blank(c))
					nxt = ST_ERR;
			end
			ST_VALUE: begin
				if (is_blank(c)) begin
					nxt = ST_VALUE;
				end else if (c == CH_QUOTE) begin
					nxt = ST_SVAL;
				end else if (c == CH_LBRACE || c == CH_LBRACK) begin
					nest_lvl = 1;
					nxt = ST_NEST;
				end else if (c == CH_COMMA || c == CH_RBRACE || c == CH_RBRACK) begin
					r.value_skipped = 1'b1;
					nxt = after_pair(c);
				end else begin
					nxt = ST_SCALAR;
				end
			end
			ST_SCALAR: begin
				if (ends_scalar(c)) begin
					r.value_skipped = 1'b1;
					nxt = after_pair(c);
				end
			end
			ST_SVAL: begin
				if (c == CH_QUOTE) begin
					r.pair_closed = 1'b1;
					if (pair_tally < TALLY_TOP)
						pair_tally++;
					nxt = ST_OBJ;
				end else begin
					r.byte_role = ROLE_VALUE;
					if (c == CH_BSLASH)
						nxt = ST_SVAL_ESC;
				end
			end
			ST_SVAL_ESC: begin
				r.byte_role = ROLE_VALUE;
				nxt = ST_SVAL;
			end
			ST_NEST: begin
				if (c == CH_LBRACE || c == CH_LBRACK) begin
					if (nest_lvl >= NEST_LIMIT)
						nxt = ST_ERR;
					else
						nest_lvl++;
				end else if (c == CH_RBRACE || c == CH_RBRACK) begin
					if (nest_lvl > 0)
						nest_lvl--;
					if (nest_lvl == 0) begin
						r.value_skipped = 1'b1;
						nxt = ST_OBJ;
					end
				end else if (c == CH_QUOTE) begin
					nxt = ST_NSTR;
				end
			end
			ST_NSTR: begin
				if (c == CH_BSLASH)
					nxt = ST_NSTR_ESC;
				else if (c == CH_QUOTE)
					nxt = ST_NEST;
			end
			ST_NSTR_ESC: nxt = ST_NSTR;
			ST_DONE: nxt = ST_DONE;
			default: nxt = ST_ERR;
		endcase
		if (nxt == ST_ERR) begin
			r.byte_role     = ROLE_NONE;
			r.field_closed  = 1'b0;
			r.pair_closed   = 1'b0;
			r.value_skipped = 1'b0;
		end
		scan_st = nxt;
		if (nxt == ST_DONE)
			r.parse_status = STATUS_OK;
		else if (nxt == ST_ERR || l)
			r.parse_status = STATUS_BAD;
		else
			r.parse_status = STATUS_BUSY;
		r.echo_byte   = c;
		r.pairs_found = (pair_tally > 64'hFFFF) ? 16'hFFFF : pair_tally[PAIRS_W-1:0];
		r.doc_end     = l;
		// a last byte closes the document: start the next one clean
		if (l) begin
			scan_st    = ST_START;
			nest_lvl   = 0;
			pair_tally = 0;
		end
		return r;
	endfunction

	always @(posedge clk) begin : scoreboard
		jtss_res_t want;
		jtss_res_t got;
		if (arst_n) begin
			if (res_out.valid && res_out.ready) begin
				got.echo_byte     = res_out.echo_byte;
				got.byte_role     = res_out.byte_role;
				got.field_closed  = res_out.field_closed;
				got.pair_closed   = res_out.pair_closed;
				got.value_skipped = res_out.value_skipped;
				got.parse_status  = res_out.parse_status;
				got.pairs_found   = res_out.pairs_found;
				got.doc_end       = res_out.doc_end;
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result with nothing expected, byte %h", $realtime,
							got.echo_byte);
				end else begin
					want = pending_results.pop_front();
					if (got.echo_byte !== want.echo_byte || got.byte_role !== want.byte_role ||
						got.field_closed !== want.field_closed ||
						got.pair_closed !== want.pair_closed ||
						got.value_skipped !== want.value_skipped ||
						got.parse_status !== want.parse_status ||
						got.pairs_found !== want.pairs_found || got.doc_end !== want.doc_end) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("%0t: mismatch exp byte=%h role=%0d fc=%b pc=%b vs=%b st=%0d pairs=%0d end=%b",
								$realtime, want.echo_byte, want.byte_role, want.field_closed,
								want.pair_closed, want.value_skipped, want.parse_status,
								want.pairs_found, want.doc_end);
							$display("%0t:          got byte=%h role=%0d fc=%b pc=%b vs=%b st=%0d pairs=%0d end=%b",
								$realtime, got.echo_byte, got.byte_role, got.field_closed,
								got.pair_closed, got.value_skipped, got.parse_status,
								got.pairs_found, got.doc_end);
						end
					end
				end
			end
			if (doc_in.valid && doc_in.ready) begin
				want = scan_step(doc_in.doc_byte, doc_in.doc_last);
				if (pin_on)
					want = pin_res;
				pending_results.push_back(want);
			end
		end
	end

	// one transfer in; idle gaps are taken before the byte is offered
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic l, input logic pin,
		input jtss_res_t pinned);
		@(negedge clk);
		while (idle_en && $urandom_range(0, 99) < 36) begin
			doc_in.valid <= 1'b0;
			@(negedge clk);
		end
		doc_in.valid    <= 1'b1;
		doc_in.doc_byte <= b;
		doc_in.doc_last <= l;
		pin_on          <= pin;
		pin_res         <= pinned;
		@(posedge clk);
		while (!doc_in.ready)
			@(posedge clk);
	endtask

	task automatic send_doc();
		for (int i = 0; i < doc_buf.size(); i++)
			send_byte(doc_buf[i], i == doc_buf.size() - 1, 1'b0, '0);
	endtask

	function automatic void add_b(input logic [BYTE_W-1:0] b);
		doc_buf.push_back(b);
	endfunction

	function automatic logic [BYTE_W-1:0] rand_byte();
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [BYTE_W-1:0] pick_blank();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic void add_blanks(input int most);
		repeat ($urandom_range(0, most))
			add_b(pick_blank());
	endfunction

	// quoted text with the odd escape; the escaped byte may be anything
	function automatic void add_text();
		logic [BYTE_W-1:0] c;
		add_b(CH_QUOTE);
		repeat ($urandom_range(0, 5)) begin
			if ($urandom_range(0, 4) == 0) begin
				add_b(CH_BSLASH);
				add_b(rand_byte());
			end else begin
				c = rand_byte();
				while (c == CH_QUOTE || c == CH_BSLASH)
					c = rand_byte();
				add_b(c);
			end
		end
		add_b(CH_QUOTE);
	endfunction

	function automatic void add_scalar();
		logic [BYTE_W-1:0] c;
		c = rand_byte();
		while (ends_scalar(c) || c == CH_QUOTE || c == CH_LBRACE || c == CH_LBRACK)
			c = rand_byte();
		add_b(c);
		repeat ($urandom_range(0, 3)) begin
			c = rand_byte();
			while (ends_scalar(c))
				c = rand_byte();
			add_b(c);
		end
	endfunction

	// brackets are not matched by kind, so mix them freely
	function automatic void add_nested(input int most);
		int depth;
		int steps;
		int r;
		logic [BYTE_W-1:0] c;
		add_b($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK);
		depth = 1;
		steps = 0;
		while (depth > 0) begin
			r = $urandom_range(0, 9);
			steps++;
			if (steps > 12)
				r = 9;
			if (r < 2 && depth < most) begin
				add_b($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK);
				depth++;
			end else if (r < 4) begin
				add_text();
			end else if (r < 7) begin
				c = rand_byte();
				while (c == CH_LBRACE || c == CH_LBRACK || c == CH_RBRACE || c == CH_RBRACK ||
					c == CH_QUOTE)
					c = rand_byte();
				add_b(c);
			end else begin
				add_b($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACK);
				depth--;
			end
		end
	endfunction

	function automatic void build_doc();
		int  npairs;
		int  kind;
		bit  comma_done;
		bit  tight;
		bit  closing;
		doc_buf.delete();
		add_blanks(2);
		add_b(CH_LBRACE);
		npairs     = $urandom_range(0, 4);
		comma_done = 1'b0;
		tight      = 1'b0;
		for (int i = 0; i < npairs; i++) begin
			closing = (i == npairs - 1);
			add_blanks(1);
			if (!comma_done && $urandom_range(0, 1)) begin
				add_b(CH_COMMA);
				add_blanks(1);
			end
			comma_done = 1'b0;
			add_text();
			add_blanks(1);
			add_b(CH_COLON);
			add_blanks(1);
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				add_text();
			end else if (kind < 7) begin
				add_scalar();
				if (closing && $urandom_range(0, 2) == 0) begin
					add_b(CH_RBRACE);
					tight = 1'b1;
				end else if (!closing && $urandom_range(0, 2) == 0) begin
					add_b(CH_COMMA);
					comma_done = 1'b1;
				end else begin
					add_b(pick_blank());
				end
			end else if (kind < 9) begin
				add_nested(3);
			end else if (closing) begin
				// empty value right before the closing brace
				add_b(CH_RBRACE);
				tight = 1'b1;
			end else begin
				add_b(CH_COMMA);
				comma_done = 1'b1;
			end
		end
		if (!tight) begin
			add_blanks(2);
			add_b(CH_RBRACE);
		end
		if ($urandom_range(0, 9) < 3)
			repeat ($urandom_range(1, 3))
				add_b(rand_byte());
	endfunction

	// break some documents: flip a byte, cut short, double a comma, or noise
	function automatic void mangle_doc();
		int r;
		int pos;
		r = $urandom_range(0, 19);
		if (r >= 14 && r <= 16) begin
			pos = $urandom_range(0, doc_buf.size() - 1);
			doc_buf[pos] = rand_byte();
		end else if (r == 17) begin
			pos = $urandom_range(1, doc_buf.size());
			while (doc_buf.size() > pos)
				void'(doc_buf.pop_back());
		end else if (r == 18) begin
			pos = $urandom_range(0, doc_buf.size() - 1);
			doc_buf.insert(pos, CH_COMMA);
			doc_buf.insert(pos, CH_COMMA);
		end else if (r == 19) begin
			doc_buf.delete();
			if ($urandom_range(0, 1))
				add_b(CH_LBRACE);
			repeat ($urandom_range(1, 8))
				add_b(rand_byte());
		end
	endfunction

	function automatic void build_deep(input int levels);
		doc_buf.delete();
		add_b(CH_LBRACE);
		add_b(CH_QUOTE);
		add_b(CH_QUOTE);
		add_b(CH_COLON);
		repeat (levels)
			add_b(CH_LBRACK);
		repeat (levels)
			add_b(CH_RBRACK);
		add_b(CH_RBRACE);
	endfunction

	initial begin
		jtss_res_t pinned;
		stim_row_t row;
		int        random_sent;
		int        doc_count;

		arst_n          = 1'b0;
		doc_in.valid    = 1'b0;
		doc_in.doc_byte = '0;
		doc_in.doc_last = 1'b0;
		res_out.ready   = 1'b0;
		pin_on          = 1'b0;
		pin_res         = '0;

		dir_table = '{
			// bad first byte, then the other extreme as a last byte
			'{8'hFF,     1'b0, 1'b1, ROLE_NONE, STATUS_BAD,  16'd0},
			'{8'h00,     1'b1, 1'b1, ROLE_NONE, STATUS_BAD,  16'd0},
			// leading comma, escaped extremes in name and value
			'{CH_LBRACE, 1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_COMMA,  1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_QUOTE,  1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_BSLASH, 1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{8'h00,     1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_QUOTE,  1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_COLON,  1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_QUOTE,  1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_BSLASH, 1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{8'hFF,     1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_QUOTE,  1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_RBRACE, 1'b1, 1'b1, ROLE_NONE, STATUS_OK,   16'd1},
			// empty value then a comma before the closing brace
			'{CH_LBRACE, 1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_QUOTE,  1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_QUOTE,  1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_COLON,  1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_COMMA,  1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_RBRACE, 1'b1, 1'b1, ROLE_NONE, STATUS_BAD,  16'd0},
			// closing bracket as an empty value lands between pairs
			'{CH_LBRACE, 1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_QUOTE,  1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_QUOTE,  1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_COLON,  1'b0, 1'b0, ROLE_NONE, STATUS_BUSY, 16'd0},
			'{CH_RBRACK, 1'b1, 1'b1, ROLE_NONE, STATUS_BAD,  16'd0}
		};

		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < DIR_ROWS; i++) begin
			row                  = dir_table[i];
			pinned               = '0;
			pinned.echo_byte     = row.b;
			pinned.byte_role     = row.role;
			pinned.parse_status  = row.st;
			pinned.pairs_found   = row.pairs;
			pinned.doc_end       = row.l;
			send_byte(row.b, row.l, row.pin, pinned);
		end

		random_sent = 0;
		doc_count   = 0;
		while (random_sent < RANDOM_ITEMS) begin
			build_doc();
			mangle_doc();
			idle_en = !(doc_count >= 30 && doc_count < 45);
			send_doc();
			random_sent += doc_buf.size();
			doc_count++;
		end

		// a long document of string pairs, back to back
		idle_en = 1'b0;
		doc_buf.delete();
		add_b(CH_LBRACE);
		repeat (LONG_PAIRS) begin
			add_b(CH_QUOTE);
			add_b(CH_QUOTE);
			add_b(CH_COLON);
			add_b(CH_QUOTE);
			add_b(CH_QUOTE);
		end
		add_b(CH_RBRACE);
		send_doc();

		idle_en = 1'b1;
		build_deep(NEST_LIMIT);
		send_doc();
		build_deep(NEST_LIMIT + 1);
		send_doc();

		@(negedge clk);
		doc_in.valid <= 1'b0;
		pin_on       <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);
		if (pending_results.size() != 0)
			fail_count++;

		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
